// File: rtl/fastq_read_splitter_defines.svh
// assertion macros used by the fastq read splitter port checker
`ifndef FASTQ_READ_SPLITTER_DEFINES_SVH
`define FASTQ_READ_SPLITTER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define FSPLT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fastq read splitter check failed");

// next-cycle implication, sampled on clk, off during rst
`define FSPLT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fastq read splitter check failed");

`endif

// File: rtl/fsplt_pkg.sv
// package: constants, codes and word types of the fastq read splitter
package fsplt_pkg;

  localparam int LINE_MAX = 1024;
  localparam int ADDR_W   = $clog2(LINE_MAX);
  localparam int FILL_W   = $clog2(LINE_MAX) + 1;
  localparam int CUT_W    = 10;
  localparam int TOTAL_W  = 34;
  localparam int COUNT_W  = 32;
  localparam int BYTE_W   = 8;
  localparam int CMD_W    = 2;
  localparam int REG_IDX_W = 1;
  localparam int CFG_W    = 10;

  localparam logic [BYTE_W-1:0] NEWLINE = 8'h0A;

  // input commands
  typedef enum logic [CMD_W-1:0] {
    CMD_DATA  = 2'd0,
    CMD_DRAIN = 2'd1,
    CMD_EOF   = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  // configuration register indexes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_MANUAL_CUT = 1'b0,
    REG_CUT_POS    = 1'b1
  } reg_idx_t;

  // result word waiting for the buffer read data
  typedef struct packed {
    logic               first_valid;
    logic               first_mem;
    logic [BYTE_W-1:0]  first_byte;
    logic               second_valid;
    logic               second_mem;
    logic [BYTE_W-1:0]  second_byte;
    logic               drain_pending;
    logic               status;
    logic               count_valid;
    logic [COUNT_W-1:0] record_total;
  } stage_t;

  // finished result word
  typedef struct packed {
    logic               first_valid;
    logic [BYTE_W-1:0]  first_byte;
    logic               second_valid;
    logic [BYTE_W-1:0]  second_byte;
    logic               drain_pending;
    logic               status;
    logic               count_valid;
    logic [COUNT_W-1:0] record_total;
  } result_t;

endpackage

// File: rtl/fsplt_if.sv
// channel interfaces: input words, result words and configuration writes
interface fsplt_in_if import fsplt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface fsplt_out_if import fsplt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               first_valid;
  logic [BYTE_W-1:0]  first_byte;
  logic               second_valid;
  logic [BYTE_W-1:0]  second_byte;
  logic               drain_pending;
  logic               status;
  logic               count_valid;
  logic [COUNT_W-1:0] record_total;

  modport source (output valid, output first_valid, output first_byte,
                  output second_valid, output second_byte, output drain_pending,
                  output status, output count_valid, output record_total,
                  input ready);
  modport sink   (input valid, input first_valid, input first_byte,
                  input second_valid, input second_byte, input drain_pending,
                  input status, input count_valid, input record_total,
                  output ready);
endinterface

interface fsplt_cfg_if import fsplt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [REG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/fastq_read_splitter.sv
// top level: fastq line splitter around a one-write two-read line buffer
// a result word passes through the s1 and output registers after its input word is accepted
// throughput: one input word per cycle unless the result side stalls; the line
//   buffer takes one write or two reads (stream one and stream two positions) per cycle
// reset (rst, synchronous): clears line counters, drain pointers, registers
//   and both pipeline valids; the line buffer is not cleared and needs no pass
module fastq_read_splitter import fsplt_pkg::*; (
  input  logic clk,
  input  logic rst,
  fsplt_in_if.sink    in,
  fsplt_out_if.source out,
  fsplt_cfg_if.sink   cfg
);

  // configuration
  logic             manual_cut;
  logic [CUT_W-1:0] cut_pos;

  // line state
  logic [FILL_W-1:0]  line_fill, fill_next;
  logic [1:0]         line_phase, phase_next;
  logic [TOTAL_W-1:0] line_total, total_next;
  logic [FILL_W-1:0]  split_point, split_next;
  logic [FILL_W-1:0]  first_pos, first_next;
  logic [FILL_W-1:0]  second_pos, second_next;
  logic               pending, pending_next;

  // line buffer
  logic [BYTE_W-1:0] line_store [LINE_MAX];
  logic              wr_en, rd_en;
  logic [BYTE_W-1:0] rd_a, rd_b;

  // pipeline
  stage_t  stage_next, s1_q;
  logic    s1_valid;
  result_t out_q, out_next;
  logic    out_valid;
  logic    s1_adv, take;

  // working values
  cmd_t              cmd;
  logic [FILL_W-1:0] fill_inc, fin_len, cut, s1len;
  logic              finish, eof_ok;

  assign cmd    = cmd_t'(in.command);
  assign s1_adv = s1_valid && (!out_valid || out.ready);
  assign in.ready = !s1_valid || s1_adv;
  assign take   = in.valid && in.ready;
  assign cfg.ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      manual_cut <= 1'b0;
      cut_pos    <= '0;
    end else if (cfg.valid) begin
      unique case (reg_idx_t'(cfg.index))
        REG_MANUAL_CUT: manual_cut <= cfg.data[0];
        REG_CUT_POS:    cut_pos    <= cfg.data[CUT_W-1:0];
      endcase
    end
  end

  // step logic for the word on the input channel
  always_comb begin
    fill_next    = line_fill;
    phase_next   = line_phase;
    total_next   = line_total;
    split_next   = split_point;
    first_next   = first_pos;
    second_next  = second_pos;
    pending_next = pending;
    stage_next   = '0;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    finish       = 1'b0;
    eof_ok       = 1'b0;
    fill_inc     = line_fill + 1'b1;
    fin_len      = line_fill;
    s1len        = (split_point < line_fill) ? split_point + 1'b1 : line_fill;
    cut          = '0;

    unique case (cmd)
      CMD_DATA: begin
        if (pending) begin
          stage_next.status = 1'b1;
        end else begin
          if (!line_phase[0]) begin
            stage_next.first_valid  = 1'b1;
            stage_next.first_byte   = in.data_byte;
            stage_next.second_valid = 1'b1;
            stage_next.second_byte  = in.data_byte;
          end else if (line_fill < FILL_W'(LINE_MAX)) begin
            wr_en = take;
          end
          fill_next = fill_inc;
          fin_len   = fill_inc;
          finish    = (in.data_byte == NEWLINE) || (fill_inc >= FILL_W'(LINE_MAX - 1));
        end
      end
      CMD_DRAIN: begin
        if (pending) begin
          rd_en = take;
          if (first_pos < s1len) begin
            stage_next.first_valid = 1'b1;
            stage_next.first_mem   = first_pos < split_point;
            stage_next.first_byte  = NEWLINE;
            first_next             = first_pos + 1'b1;
          end
          if (second_pos < line_fill) begin
            stage_next.second_valid = 1'b1;
            stage_next.second_mem   = 1'b1;
            second_next             = second_pos + 1'b1;
          end
          if (first_next >= s1len && second_next >= line_fill) begin
            pending_next = 1'b0;
            fill_next    = '0;
          end
        end
      end
      CMD_EOF: begin
        if (pending) begin
          stage_next.status = 1'b1;
        end else begin
          finish = line_fill != '0;
          eof_ok = 1'b1;
        end
      end
      CMD_NOP: begin
      end
    endcase

    // line complete: count it, arm the drain on sequence and quality lines
    if (finish) begin
      if (line_phase[0]) begin
        cut          = manual_cut ? FILL_W'(cut_pos) : (fin_len >> 1);
        split_next   = (cut < fin_len) ? cut : fin_len;
        first_next   = '0;
        second_next  = (cut < fin_len) ? cut : fin_len;
        pending_next = 1'b1;
      end else begin
        fill_next = '0;
      end
      total_next = line_total + 1'b1;
      phase_next = line_phase + 1'b1;
    end

    // end of file report
    if (eof_ok) begin
      stage_next.count_valid  = 1'b1;
      stage_next.record_total = total_next[TOTAL_W-1:2];
      total_next = '0;
      phase_next = '0;
    end

    stage_next.drain_pending = pending_next;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      line_fill   <= '0;
      line_phase  <= '0;
      line_total  <= '0;
      split_point <= '0;
      first_pos   <= '0;
      second_pos  <= '0;
      pending     <= 1'b0;
    end else if (take) begin
      line_fill   <= fill_next;
      line_phase  <= phase_next;
      line_total  <= total_next;
      split_point <= split_next;
      first_pos   <= first_next;
      second_pos  <= second_next;
      pending     <= pending_next;
    end
  end

  // line buffer: writes only while filling, reads only while draining,
  // so a read never meets a write to the same entry in one cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_store[line_fill[ADDR_W-1:0]] <= in.data_byte;
    end
    if (rd_en) begin
      rd_a <= line_store[first_pos[ADDR_W-1:0]];
      rd_b <= line_store[second_pos[ADDR_W-1:0]];
    end
  end

  // merge buffer read data into the result word
  always_comb begin
    out_next.first_valid   = s1_q.first_valid;
    out_next.first_byte    = s1_q.first_mem ? rd_a : s1_q.first_byte;
    out_next.second_valid  = s1_q.second_valid;
    out_next.second_byte   = s1_q.second_mem ? rd_b : s1_q.second_byte;
    out_next.drain_pending = s1_q.drain_pending;
    out_next.status        = s1_q.status;
    out_next.count_valid   = s1_q.count_valid;
    out_next.record_total  = s1_q.record_total;
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in.ready) begin
        s1_valid <= take;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (take) begin
      s1_q <= stage_next;
    end
    if (s1_adv) begin
      out_q <= out_next;
    end
  end

  // output word
  assign out.valid         = out_valid;
  assign out.first_valid   = out_q.first_valid;
  assign out.first_byte    = out_q.first_byte;
  assign out.second_valid  = out_q.second_valid;
  assign out.second_byte   = out_q.second_byte;
  assign out.drain_pending = out_q.drain_pending;
  assign out.status        = out_q.status;
  assign out.count_valid   = out_q.count_valid;
  assign out.record_total  = out_q.record_total;

endmodule

// File: rtl/fsplt_checker.sv
// port checker for the fastq read splitter, bound to the top level
`include "fastq_read_splitter_defines.svh"

module fsplt_checker import fsplt_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic               first_valid,
  input logic [BYTE_W-1:0]  first_byte,
  input logic               second_valid,
  input logic [BYTE_W-1:0]  second_byte,
  input logic               drain_pending,
  input logic               status,
  input logic               count_valid,
  input logic [COUNT_W-1:0] record_total
);

  // a stalled result word holds
  `FSPLT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(first_byte) && $stable(second_byte) && $stable(record_total) && $stable(status))

  // bytes without their valid read as zero
  `FSPLT_ASSERT_NOW(a_idle_bytes, out_valid, (first_valid || first_byte == '0) && (second_valid || second_byte == '0))

  // a rejected word emits nothing and is only rejected while a drain waits
  `FSPLT_ASSERT_NOW(a_reject, out_valid && status, !first_valid && !second_valid && !count_valid && drain_pending)

  // an end of file report carries no stream bytes
  `FSPLT_ASSERT_NOW(a_eof_quiet, out_valid && count_valid, !first_valid && !second_valid && !status)

endmodule

bind fastq_read_splitter fsplt_checker u_fsplt_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out.valid),
  .out_ready     (out.ready),
  .first_valid   (out.first_valid),
  .first_byte    (out.first_byte),
  .second_valid  (out.second_valid),
  .second_byte   (out.second_byte),
  .drain_pending (out.drain_pending),
  .status        (out.status),
  .count_valid   (out.count_valid),
  .record_total  (out.record_total)
);

// File: dv/fastq_read_splitter_checker.sv
// checker for the fastq read splitter: line split prediction and result comparison
`timescale 1ns / 100ps

module fastq_read_splitter_checker import fsplt_pkg::*; (
  input  logic clk,
  input  logic rst,
  fsplt_in_if  in,
  fsplt_out_if out,
  fsplt_cfg_if cfg,
  output int   failures,
  output int   outstanding
);

  // predicted splitter state
  logic [BYTE_W-1:0]  line_buf [LINE_MAX];
  logic [FILL_W-1:0]  fill;
  logic [1:0]         phase;
  logic [TOTAL_W-1:0] lines_seen;
  logic [FILL_W-1:0]  cut_at;
  logic [FILL_W-1:0]  pos1;
  logic [FILL_W-1:0]  pos2;
  logic               draining;
  logic               manual_mode;
  logic [CUT_W-1:0]   cut_reg;

  result_t expected_words[$];
  int      fail_count;

  // a line has ended: count it, arm the drain for sequence and quality lines
  function automatic void close_line();
    logic [FILL_W-1:0] cut;
    if (phase == 2'd1 || phase == 2'd3) begin
      cut      = manual_mode ? FILL_W'(cut_reg) : (fill >> 1);
      cut_at   = (cut < fill) ? cut : fill;
      pos1     = '0;
      pos2     = cut_at;
      draining = 1'b1;
    end else begin
      fill = '0;
    end
    lines_seen = lines_seen + 1'b1;
    phase      = phase + 2'd1;
  endfunction

  // work out the result word of one accepted input word
  function automatic result_t split_word(cmd_t cmd, logic [BYTE_W-1:0] b);
    result_t           r;
    logic [FILL_W-1:0] s1len;
    r = '0;
    case (cmd)
      CMD_DATA: begin
        if (draining) begin
          r.status = 1'b1;
        end else begin
          if (phase == 2'd0 || phase == 2'd2) begin
            r.first_valid  = 1'b1;
            r.first_byte   = b;
            r.second_valid = 1'b1;
            r.second_byte  = b;
          end else if (fill < LINE_MAX) begin
            line_buf[fill[ADDR_W-1:0]] = b;
          end
          fill = fill + 1'b1;
          if (b == NEWLINE || fill >= LINE_MAX - 1) close_line();
        end
      end
      CMD_DRAIN: begin
        if (draining) begin
          s1len = (cut_at < fill) ? cut_at + 1'b1 : fill;
          if (pos1 < s1len) begin
            r.first_valid = 1'b1;
            r.first_byte  = (pos1 < cut_at) ? line_buf[pos1[ADDR_W-1:0]] : NEWLINE;
            pos1 = pos1 + 1'b1;
          end
          if (pos2 < fill) begin
            r.second_valid = 1'b1;
            r.second_byte  = line_buf[pos2[ADDR_W-1:0]];
            pos2 = pos2 + 1'b1;
          end
          if (pos1 >= s1len && pos2 >= fill) begin
            draining = 1'b0;
            fill     = '0;
          end
        end
      end
      CMD_EOF: begin
        if (draining) begin
          r.status = 1'b1;
        end else begin
          if (fill != '0) close_line();
          r.count_valid  = 1'b1;
          r.record_total = lines_seen[TOTAL_W-1:2];
          lines_seen     = '0;
          phase          = 2'd0;
        end
      end
      default: ;
    endcase
    r.drain_pending = draining;
    return r;
  endfunction

  function automatic void compare_field(string name, logic [COUNT_W-1:0] want,
                                        logic [COUNT_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // watch the three channels at every edge
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      for (int i = 0; i < LINE_MAX; i++) line_buf[i] = '0;
      fill        = '0;
      phase       = '0;
      lines_seen  = '0;
      cut_at      = '0;
      pos1        = '0;
      pos2        = '0;
      draining    = 1'b0;
      manual_mode = 1'b0;
      cut_reg     = '0;
      fail_count  = 0;
      expected_words.delete();
    end else begin
      // register writes
      if (cfg.valid && cfg.ready) begin
        case (reg_idx_t'(cfg.index))
          REG_MANUAL_CUT: manual_mode = cfg.data[0];
          REG_CUT_POS:    cut_reg     = cfg.data[CUT_W-1:0];
          default: ;
        endcase
      end
      // accepted input word
      if (in.valid && in.ready)
        expected_words.push_back(split_word(cmd_t'(in.command), in.data_byte));
      // accepted result word against the oldest expectation
      if (out.valid && out.ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: result word with nothing expected, first %0h second %0h",
                   $time, out.first_byte, out.second_byte);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          compare_field("first_valid", COUNT_W'(want.first_valid),
                        COUNT_W'(out.first_valid));
          compare_field("first_byte", COUNT_W'(want.first_byte),
                        COUNT_W'(out.first_byte));
          compare_field("second_valid", COUNT_W'(want.second_valid),
                        COUNT_W'(out.second_valid));
          compare_field("second_byte", COUNT_W'(want.second_byte),
                        COUNT_W'(out.second_byte));
          compare_field("drain_pending", COUNT_W'(want.drain_pending),
                        COUNT_W'(out.drain_pending));
          compare_field("status", COUNT_W'(want.status), COUNT_W'(out.status));
          compare_field("count_valid", COUNT_W'(want.count_valid),
                        COUNT_W'(out.count_valid));
          compare_field("record_total", want.record_total, out.record_total);
        end
      end
    end
    failures    <= fail_count;
    outstanding <= expected_words.size();
  end

endmodule

// File: dv/tb_fastq_read_splitter.sv
// testbench top: fastq text and drain stimulus, stalls, register phases and verdict
`timescale 1ns / 100ps

module tb_fastq_read_splitter;
  import fsplt_pkg::*;

  localparam int TARGET_WORDS = 950;
  localparam int HOLD_CYCLES  = 64;
  localparam int STUCK_LIMIT  = 600;

  logic clk = 1'b0;
  logic rst = 1'b1;

  fsplt_in_if  in_ch ();
  fsplt_out_if out_ch ();
  fsplt_cfg_if cfg_ch ();

  int failures;
  int outstanding;
  int sent;
  int stuck;
  bit gaps_on;
  bit hold_off;
  bit loose_ticks;
  bit cut_manual;
  int cut_pos;

  fastq_read_splitter i_dut (
    .clk (clk),
    .rst (rst),
    .in  (in_ch),
    .out (out_ch),
    .cfg (cfg_ch)
  );

  fastq_read_splitter_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .in          (in_ch),
    .out         (out_ch),
    .cfg         (cfg_ch),
    .failures    (failures),
    .outstanding (outstanding)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // no handshake on any channel for too long ends the run
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stuck <= 0;
    end else if (stuck >= STUCK_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  // result side: short random stalls, one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        out_ch.ready <= 1'b0;
      end else if (hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        stall_left = $urandom_range(0, 2);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // one input word, with an occasional gap before it
  task automatic send_word(cmd_t cmd, logic [BYTE_W-1:0] b);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.command   <= cmd;
    in_ch.data_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  // stop offering words and wait until every result word is back
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // one register word; the caller drops valid after its last write
  task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic set_cut(bit manual, int pos);
    wait_idle();
    write_reg(REG_CUT_POS, CFG_W'(pos));
    write_reg(REG_MANUAL_CUT, CFG_W'(manual));
    cfg_ch.valid <= 1'b0;
    cut_manual = manual;
    cut_pos    = pos;
  endtask

  // any text byte but a newline
  function automatic logic [BYTE_W-1:0] text_byte();
    logic [BYTE_W-1:0] b;
    b = BYTE_W'($urandom_range(0, 255));
    if (b == NEWLINE) b = 8'h4E;
    return b;
  endfunction

  // ticks to empty a buffered line of len bytes, a little off at random when loose
  task automatic drain(int len);
    int cut, split, s1, n;
    cut   = cut_manual ? cut_pos : len / 2;
    split = (cut < len) ? cut : len;
    s1    = (split < len) ? split + 1 : len;
    n     = (s1 > len - split) ? s1 : len - split;
    if (loose_ticks) begin
      case ($urandom_range(0, 9))
        0: n = n + $urandom_range(1, 2);
        1: n = n - $urandom_range(0, 2);
        default: ;
      endcase
    end
    repeat (n) send_word(CMD_DRAIN, BYTE_W'($urandom_range(0, 255)));
  endtask

  task automatic send_line(int len, bit buffered);
    repeat (len - 1) send_word(CMD_DATA, text_byte());
    send_word(CMD_DATA, NEWLINE);
    if (buffered) drain(len);
  endtask

  // header, sequence, plus and quality line of one read
  task automatic send_record(int seq_len);
    send_line($urandom_range(1, 8), 1'b0);
    send_line(seq_len, 1'b1);
    send_line($urandom_range(1, 3), 1'b0);
    send_line(seq_len, 1'b1);
  endtask

  // stimulus
  initial begin
    int next_cfg, pick;
    in_ch.valid      <= 1'b0;
    in_ch.command    <= CMD_NOP;
    in_ch.data_byte  <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= REG_MANUAL_CUT;
    cfg_ch.data      <= '0;
    sent        = 0;
    gaps_on     = 1'b1;
    hold_off    = 1'b0;
    loose_ticks = 1'b0;
    cut_manual  = 1'b0;
    cut_pos     = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // header with both byte extremes, copied to both streams
    set_cut(1'b0, 0);
    send_word(CMD_DATA, 8'h00);
    send_word(CMD_DATA, 8'hFF);
    send_word(CMD_DATA, NEWLINE);
    // sequence line cut at half its length; byte and end of file refused meanwhile
    send_word(CMD_DATA, "A");
    send_word(CMD_DATA, "C");
    send_word(CMD_DATA, "G");
    send_word(CMD_DATA, NEWLINE);
    send_word(CMD_DATA, "T");
    send_word(CMD_EOF, 8'h00);
    drain(4);
    // idle drain tick and the unused command
    send_word(CMD_DRAIN, 8'h00);
    send_word(CMD_NOP, 8'h5A);
    // plus line, then a quality line holding just the newline
    send_line(2, 1'b0);
    send_line(1, 1'b1);
    // partial header flushed by end of file, then an empty file
    send_word(CMD_DATA, "@");
    send_word(CMD_EOF, 8'h00);
    send_word(CMD_EOF, 8'h00);

    // manual cut at zero: stream one gets only the newline
    set_cut(1'b1, 0);
    send_record(3);
    // cut past the line end: stream one gets the whole line
    set_cut(1'b1, 1023);
    send_record(4);
    // partial sequence line flushed by end of file still drains
    send_line(2, 1'b0);
    send_word(CMD_DATA, "G");
    send_word(CMD_DATA, "T");
    send_word(CMD_EOF, 8'h00);
    drain(2);

    // one overlong sequence line, chunked, drained against a long hold-off
    set_cut(1'b0, 0);
    send_line(5, 1'b0);
    repeat (LINE_MAX - 1) send_word(CMD_DATA, text_byte());
    hold_off = 1'b1;
    drain(LINE_MAX - 1);
    send_line(8, 1'b0);
    send_line(3, 1'b1);
    send_word(CMD_EOF, 8'h00);

    // random reads under changing cut settings, with some noise
    loose_ticks = 1'b1;
    sent        = 0;
    next_cfg    = 0;
    while (sent < TARGET_WORDS) begin
      if (sent >= next_cfg) begin
        case ($urandom_range(0, 4))
          0: set_cut(1'b0, $urandom_range(0, 1023));
          1: set_cut(1'b1, 0);
          2: set_cut(1'b1, 1023);
          3: set_cut(1'b1, $urandom_range(1, 45));
          default: set_cut(1'b1, $urandom_range(0, 1023));
        endcase
        next_cfg = sent + $urandom_range(120, 200);
      end
      if (TARGET_WORDS - sent < 150) gaps_on = 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        send_record(($urandom_range(0, 19) == 0) ? $urandom_range(100, 200)
                                                  : $urandom_range(1, 40));
      end else if (pick < 87) begin
        send_record($urandom_range(1, 40));
        send_word(CMD_EOF, BYTE_W'($urandom_range(0, 255)));
      end else begin
        // noise, then ticks and an end of file to get back in step
        repeat ($urandom_range(1, 6))
          send_word(cmd_t'($urandom_range(0, 3)), BYTE_W'($urandom_range(0, 255)));
        repeat (8) send_word(CMD_DRAIN, BYTE_W'($urandom_range(0, 255)));
        send_word(CMD_EOF, BYTE_W'($urandom_range(0, 255)));
      end
    end

    // let the last results come back
    wait_idle();
    repeat (4) @(posedge clk);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
